// ===== sv/lis_pkg.sv =====
// Shared types, constants and width helpers for the longest increasing subsequence block.
package lis_pkg;

   localparam int LIS_MAX_ELEMENTS = 256;
   localparam int LIS_VALUE_W      = 32;
   localparam int LIS_LENGTH_W     = 9;

   // Flip the sign bit so that an unsigned compare orders two's complement values.
   localparam logic [LIS_VALUE_W-1:0] LIS_SIGN_FLIP = {1'b1, {(LIS_VALUE_W-1){1'b0}}};

   typedef struct packed {
      logic                   is_last;
      logic [LIS_VALUE_W-1:0] element_value;
   } item_type;

   typedef struct packed {
      logic                    overflowed;
      logic [LIS_LENGTH_W-1:0] lis_length;
   } result_type;

   // Address width of a store with the given depth; at least one bit.
   function automatic int lis_addr_w(input int depth);
      lis_addr_w = (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // Width of a counter that can hold the depth itself.
   function automatic int lis_count_w(input int depth);
      lis_count_w = $clog2(depth + 1);
   endfunction

endpackage

// ===== sv/longest_increasing_subsequence.sv =====
// Top level: stream ports, scan sequencer and result output register.
//
//   channel | dir | tdata bits (low first)      | tuser          | tlast
//   req_    | in  | [31:0] element_value        | -              | is_last
//   rsp_    | out | [8:0] lis_length, [15:9] 0  | [0] overflowed | -
//
// An element is compared with every element already stored in the sequence: one read of the
// element store per cycle, then the scan waits for the last read to return, leaves the scan,
// writes the element back and only then accepts the next element. The first element of a
// sequence skips the scan and goes straight to write-back, a dropped element (store full) is
// not stored at all, and an element marked last is followed by the hand-over of its result.
// Sync reset clears the count, best, flag and both valids; the store contents are left as
// they are. The output register holds a result until it is taken while the block scans the
// next sequence; a further end-of-sequence result waits in the sequencer until that register
// frees up.
module longest_increasing_subsequence
   import lis_pkg::*;
#(
   parameter int MAX_ELEMENTS = LIS_MAX_ELEMENTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] element_value
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [8:0] lis_length, [15:9] zero
   output logic        rsp_tuser    // [0] overflowed
);

   item_type   item;
   result_type res;
   logic       res_valid;
   logic       res_ready;

   logic       rsp_valid_ff;
   result_type rsp_res_ff;

   assign item.element_value = req_tdata;
   assign item.is_last       = req_tlast;

   lis_core #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // load a new result when the register is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(16 - LIS_LENGTH_W)'(0), rsp_res_ff.lis_length};
   assign rsp_tuser  = rsp_res_ff.overflowed;

endmodule

// ===== sv/lis_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lis_ram
   import lis_pkg::*;
#(
   parameter  int WIDTH = LIS_VALUE_W,
   parameter  int DEPTH = LIS_MAX_ELEMENTS,
   localparam int AW    = lis_addr_w(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lis_core.sv =====
// Scan sequencer: reads every stored element, builds the new length, writes it back; drops the element when full.
module lis_core
   import lis_pkg::*;
#(
   parameter int MAX_ELEMENTS = LIS_MAX_ELEMENTS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   output logic       item_ready,
   input  item_type   item,
   output logic       res_valid,
   input  logic       res_ready,
   output result_type res
);

   localparam int AW = lis_addr_w(MAX_ELEMENTS);
   localparam int CW = lis_count_w(MAX_ELEMENTS);
   localparam int EW = LIS_VALUE_W + CW;
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ELEMENTS);
   localparam logic [CW-1:0] ONE_LENGTH = CW'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_RESULT
   } state_type;

   state_type              state_ff;
   logic [LIS_VALUE_W-1:0] key_ff;
   logic                   last_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          best_ff;
   logic                   ovf_ff;
   logic [CW-1:0]          rd_addr_ff;
   logic                   rd_pend_ff;
   logic [CW-1:0]          len_ff;

   logic                   rd_issue;
   logic                   wr_en;
   logic [EW-1:0]          wr_data;
   logic [EW-1:0]          rd_data;
   logic [LIS_VALUE_W-1:0] rd_key;
   logic [CW-1:0]          rd_len_inc;
   logic                   take_len;

   assign rd_issue   = (state_ff == ST_SCAN) && (rd_addr_ff != count_ff);
   assign wr_en      = (state_ff == ST_WRITE);
   assign wr_data    = {len_ff, key_ff};
   assign rd_key     = rd_data[LIS_VALUE_W-1:0];
   assign rd_len_inc = rd_data[EW-1:LIS_VALUE_W] + ONE_LENGTH;
   assign take_len   = rd_pend_ff && (rd_key < key_ff) && (rd_len_inc > len_ff);

   lis_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign item_ready     = (state_ff == ST_IDLE);
   assign res_valid      = (state_ff == ST_RESULT);
   assign res.lis_length = LIS_LENGTH_W'(best_ff);
   assign res.overflowed = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         best_ff    <= '0;
         ovf_ff     <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               rd_pend_ff <= 1'b0;
               if (item_valid) begin
                  key_ff     <= item.element_value ^ LIS_SIGN_FLIP;
                  last_ff    <= item.is_last;
                  len_ff     <= ONE_LENGTH;
                  rd_addr_ff <= '0;
                  if (count_ff == FULL_COUNT) begin
                     // drop the element, keep its end-of-sequence mark
                     ovf_ff   <= 1'b1;
                     state_ff <= item.is_last ? ST_RESULT : ST_IDLE;
                  end else if (count_ff == '0) begin
                     state_ff <= ST_WRITE;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               rd_pend_ff <= rd_issue;
               if (rd_issue) begin
                  rd_addr_ff <= rd_addr_ff + ONE_LENGTH;
               end
               if (take_len) begin
                  len_ff <= rd_len_inc;
               end
               // leave once the final read has returned
               if (!rd_issue && !rd_pend_ff) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               count_ff <= count_ff + ONE_LENGTH;
               if (len_ff > best_ff) begin
                  best_ff <= len_ff;
               end
               state_ff <= last_ff ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT: begin
               if (res_ready) begin
                  count_ff <= '0;
                  best_ff  <= '0;
                  ovf_ff   <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== sv/lis_checker.sv =====
// Port-level checks for the longest increasing subsequence block, bound to the top level.
module lis_checker
   import lis_pkg::*;
#(
   parameter int MAX_ELEMENTS = LIS_MAX_ELEMENTS
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   localparam bit WRAPS = (MAX_ELEMENTS > 511);
   localparam logic [LIS_LENGTH_W-1:0] MAX_LEN = LIS_LENGTH_W'(MAX_ELEMENTS);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // every sequence stores its first element, so the length is at least one
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !WRAPS |-> rsp_tdata[LIS_LENGTH_W-1:0] != '0)
      else $error("zero length result");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !WRAPS |-> rsp_tdata[LIS_LENGTH_W-1:0] <= MAX_LEN
         && rsp_tdata[15:LIS_LENGTH_W] == '0)
      else $error("result length out of range");

   // an item not marked last cannot raise a result word at the output: the core takes
   // items only while it holds no result, so the output register has none to load
   a_in_no_overlap_unused: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> !$rose(rsp_tvalid))
      else $error("result raised by an item not marked last");

endmodule

bind longest_increasing_subsequence lis_checker #(
   .MAX_ELEMENTS (MAX_ELEMENTS)
) u_lis_checker (.*);
